[sv/dvdd_pkg.sv]
// ----------------------------------------------------------------------------
// dvdd_pkg
// Types, codes and constant tables for the date check and day difference block.
// ----------------------------------------------------------------------------
package dvdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int NUM_W   = 24;   // exact day numbers and differences
  localparam int OUT_W   = 23;   // width of the numeric result fields

  // ceil(2^20 / 25): x / 25 == (x * RECIP25) >> 20 for x below 4096
  localparam logic [15:0] RECIP25 = 16'd41944;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_YEAR_ERR  = 2'd1,
    STATUS_MONTH_ERR = 2'd2,
    STATUS_DAY_ERR   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ORDER_EARLIER = 2'd0,
    ORDER_EQUAL   = 2'd1,
    ORDER_LATER   = 2'd2
  } order_t;

  typedef enum logic {
    REG_YEAR_FLOOR   = 1'b0,
    REG_CURRENT_YEAR = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // (153 * m - 457) / 5 on the month after the shift of January and February
  // to months 13 and 14 of the year before; month 0 counts as a low month.
  function automatic logic [8:0] month_term(input logic [MONTH_W-1:0] m);
    logic [8:0] t;
    unique case (m)
      4'd0:    t = 9'd275;
      4'd1:    t = 9'd306;
      4'd2:    t = 9'd337;
      4'd3:    t = 9'd0;
      4'd4:    t = 9'd31;
      4'd5:    t = 9'd61;
      4'd6:    t = 9'd92;
      4'd7:    t = 9'd122;
      4'd8:    t = 9'd153;
      4'd9:    t = 9'd184;
      4'd10:   t = 9'd214;
      4'd11:   t = 9'd245;
      4'd12:   t = 9'd275;
      4'd13:   t = 9'd306;
      4'd14:   t = 9'd337;
      default: t = 9'd367;
    endcase
    return t;
  endfunction

  // Common-year month length; invalid months never reach the day check.
  function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
    logic [4:0] l;
    unique case (m)
      4'd2:                      l = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
      default:                   l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

[sv/dvdd_in_if.sv]
// ----------------------------------------------------------------------------
// dvdd_in_if
// Input channel: a pair of dates per item.
// ----------------------------------------------------------------------------
interface dvdd_in_if;
  logic                            valid;
  logic                            ready;
  logic [dvdd_pkg::YEAR_W-1:0]     year_a;
  logic [dvdd_pkg::MONTH_W-1:0]    month_a;
  logic [dvdd_pkg::DAY_W-1:0]      day_a;
  logic [dvdd_pkg::YEAR_W-1:0]     year_b;
  logic [dvdd_pkg::MONTH_W-1:0]    month_b;
  logic [dvdd_pkg::DAY_W-1:0]      day_b;

  modport source (output valid, year_a, month_a, day_a, year_b, month_b, day_b,
                  input ready);
  modport sink   (input valid, year_a, month_a, day_a, year_b, month_b, day_b,
                  output ready);
endinterface

[sv/dvdd_out_if.sv]
// ----------------------------------------------------------------------------
// dvdd_out_if
// Result channel: check status, day number, difference and order per item.
// ----------------------------------------------------------------------------
interface dvdd_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status_a;
  logic [1:0]                        status_b;
  logic signed [dvdd_pkg::OUT_W-1:0] day_number_a;
  logic signed [dvdd_pkg::OUT_W-1:0] day_difference;
  logic [1:0]                        order;

  modport source (output valid, status_a, status_b, day_number_a, day_difference,
                  order, input ready);
  modport sink   (input valid, status_a, status_b, day_number_a, day_difference,
                  order, output ready);
endinterface

[sv/dvdd_cfg_if.sv]
// ----------------------------------------------------------------------------
// dvdd_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface dvdd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic                        index;
  logic [dvdd_pkg::YEAR_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/dvdd_date.sv]
// ----------------------------------------------------------------------------
// dvdd_date
// Three-stage pipe for one date: range check, Rata Die day number.
// ----------------------------------------------------------------------------
module dvdd_date (
  input  logic                               clk,
  input  dvdd_pkg::stage_en_t                en,
  input  logic [dvdd_pkg::YEAR_W-1:0]        year,
  input  logic [dvdd_pkg::MONTH_W-1:0]       month,
  input  logic [dvdd_pkg::DAY_W-1:0]         day,
  input  logic [dvdd_pkg::YEAR_W-1:0]        year_floor,
  input  logic [dvdd_pkg::YEAR_W-1:0]        current_year,
  output dvdd_pkg::status_t                  status,
  output logic signed [dvdd_pkg::NUM_W-1:0]  day_num
);

  // stage 1: year shift, tables, year and month checks
  logic                          low_month;
  logic                          neg_year;
  logic [dvdd_pkg::YEAR_W-1:0]   yadj_next;

  logic [dvdd_pkg::YEAR_W-1:0]   s1_year;
  logic [dvdd_pkg::YEAR_W-1:0]   s1_yadj;
  logic                          s1_neg;
  logic [8:0]                    s1_mterm;
  logic [4:0]                    s1_mlen;
  logic                          s1_feb;
  logic [dvdd_pkg::DAY_W-1:0]    s1_day;
  logic                          s1_yerr;
  logic                          s1_merr;

  always_comb begin
    low_month = (month < 4'd3);
    neg_year  = low_month && (year == '0);
    // year 0 before March is year -1: the century terms truncate to zero
    yadj_next = neg_year ? '0 : year - dvdd_pkg::YEAR_W'(low_month);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_year  <= year;
      s1_yadj  <= yadj_next;
      s1_neg   <= neg_year;
      s1_mterm <= dvdd_pkg::month_term(month);
      s1_mlen  <= dvdd_pkg::month_len(month);
      s1_feb   <= (month == 4'd2);
      s1_day   <= day;
      s1_yerr  <= (year < year_floor) ||
                  ({1'b0, year} > ({1'b0, current_year} + 15'd1));
      s1_merr  <= (month == 4'd0) || (month > 4'd12);
    end
  end

  // stage 2: divisions by 100 and 400 through the reciprocal of 25
  logic [27:0] prod_c;
  logic [25:0] prod_q;
  logic [27:0] prod_r;

  logic [dvdd_pkg::YEAR_W-1:0]   s2_year;
  logic [dvdd_pkg::YEAR_W-1:0]   s2_yadj;
  logic                          s2_neg;
  logic [7:0]                    s2_q100;
  logic [5:0]                    s2_q400;
  logic [7:0]                    s2_qraw;
  logic [8:0]                    s2_mterm;
  logic [4:0]                    s2_mlen;
  logic                          s2_feb;
  logic [dvdd_pkg::DAY_W-1:0]    s2_day;
  logic                          s2_yerr;
  logic                          s2_merr;

  always_comb begin
    prod_c = 28'(s1_yadj[13:2]) * 28'(dvdd_pkg::RECIP25);
    prod_q = 26'(s1_yadj[13:4]) * 26'(dvdd_pkg::RECIP25);
    prod_r = 28'(s1_year[13:2]) * 28'(dvdd_pkg::RECIP25);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2_year  <= s1_year;
      s2_yadj  <= s1_yadj;
      s2_neg   <= s1_neg;
      s2_q100  <= prod_c[27:20];
      s2_q400  <= prod_q[25:20];
      s2_qraw  <= prod_r[27:20];
      s2_mterm <= s1_mterm;
      s2_mlen  <= s1_mlen;
      s2_feb   <= s1_feb;
      s2_day   <= s1_day;
      s2_yerr  <= s1_yerr;
      s2_merr  <= s1_merr;
    end
  end

  // stage 3: leap rule, day check, day number sum
  logic                          leap;
  logic [4:0]                    len;
  logic                          day_err;
  logic [dvdd_pkg::NUM_W-1:0]    pos_sum;
  logic [dvdd_pkg::NUM_W-1:0]    num_next;
  dvdd_pkg::status_t             status_next;

  always_comb begin
    // leap: divisible by 4, and not a century unless the century count is a multiple of 4
    leap    = (s2_year[1:0] == 2'b00) &&
              ((14'(s2_qraw) * 14'd100 != s2_year) || (s2_qraw[1:0] == 2'b00));
    len     = s2_mlen + 5'(s2_feb && leap);
    day_err = (s2_day == '0) || (s2_day > len);

    pos_sum  = dvdd_pkg::NUM_W'(s2_yadj) * 24'd365 +
               dvdd_pkg::NUM_W'(s2_yadj[13:2]) +
               dvdd_pkg::NUM_W'(s2_q400) +
               dvdd_pkg::NUM_W'(s2_mterm) +
               dvdd_pkg::NUM_W'(s2_day);
    num_next = pos_sum - dvdd_pkg::NUM_W'(s2_q100) - 24'd306 -
               (s2_neg ? 24'd365 : 24'd0);

    priority if (s2_yerr) status_next = dvdd_pkg::STATUS_YEAR_ERR;
    else if (s2_merr)     status_next = dvdd_pkg::STATUS_MONTH_ERR;
    else if (day_err)     status_next = dvdd_pkg::STATUS_DAY_ERR;
    else                  status_next = dvdd_pkg::STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      status  <= status_next;
      day_num <= $signed(num_next);
    end
  end

endmodule

[sv/date_validate_and_day_difference.sv]
// An accepted item passes the stage 1, 2 and 3 registers, then the output register.
// Throughput: one item per cycle; each stage holds under a stall and frees
// as soon as the stage after it moves, so bubbles are squeezed out.
// Per date: check and tables, reciprocal multiplies, day number sum; then
// difference and order in the output stage.
// Reset (rst, synchronous): pipe empties, year floor 1500, current_year 2023.
// ----------------------------------------------------------------------------
// date_validate_and_day_difference
// Checks two Gregorian dates and gives Rata Die number, difference and order.
// ----------------------------------------------------------------------------
module date_validate_and_day_difference (
  input  logic     clk,
  input  logic     rst,
  dvdd_in_if.sink  dates,
  dvdd_out_if.source result,
  dvdd_cfg_if.sink cfg
);

  logic [dvdd_pkg::YEAR_W-1:0] year_floor;
  logic [dvdd_pkg::YEAR_W-1:0] current_year;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_floor   <= 14'd1500;
      current_year <= 14'd2023;
    end else if (cfg.valid) begin
      unique case (dvdd_pkg::reg_index_t'(cfg.index))
        dvdd_pkg::REG_YEAR_FLOOR:   year_floor   <= cfg.data;
        dvdd_pkg::REG_CURRENT_YEAR: current_year <= cfg.data;
        default: ;
      endcase
    end
  end

  // stage valids and enables; a stage loads when empty or when its successor moves
  logic v1, v2, v3;
  logic en4;
  dvdd_pkg::stage_en_t en;

  always_comb begin
    en4   = !result.valid || result.ready;
    en.s3 = !v3 || en4;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign dates.ready = en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (en.s1) v1 <= dates.valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en4)   result.valid <= v3;
    end
  end

  dvdd_pkg::status_t                 st_a, st_b;
  logic signed [dvdd_pkg::NUM_W-1:0] num_a, num_b;

  dvdd_date u_date_a (
    .clk          (clk),
    .en           (en),
    .year         (dates.year_a),
    .month        (dates.month_a),
    .day          (dates.day_a),
    .year_floor   (year_floor),
    .current_year (current_year),
    .status       (st_a),
    .day_num      (num_a)
  );

  dvdd_date u_date_b (
    .clk          (clk),
    .en           (en),
    .year         (dates.year_b),
    .month        (dates.month_b),
    .day          (dates.day_b),
    .year_floor   (year_floor),
    .current_year (current_year),
    .status       (st_b),
    .day_num      (num_b)
  );

  // output stage: difference and order on exact 24-bit values
  logic signed [dvdd_pkg::NUM_W-1:0] diff;
  dvdd_pkg::order_t                  order_next;

  always_comb begin
    diff = num_a - num_b;
    priority if (num_a < num_b)  order_next = dvdd_pkg::ORDER_EARLIER;
    else if (num_a == num_b)     order_next = dvdd_pkg::ORDER_EQUAL;
    else                         order_next = dvdd_pkg::ORDER_LATER;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      result.status_a       <= st_a;
      result.status_b       <= st_b;
      result.day_number_a   <= num_a[dvdd_pkg::OUT_W-1:0];
      result.day_difference <= diff[dvdd_pkg::OUT_W-1:0];
      result.order          <= order_next;
    end
  end

`ifndef NO_ASSERTIONS
  // an accepted item always occupies the first stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (dates.valid && dates.ready) |=> v1)
    else $error("accepted item not captured in first stage");

  // a full pipe with a stalled output must refuse input
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && result.valid && !result.ready) |-> !dates.ready)
    else $error("input accepted into a full stalled pipe");

  // zero difference and equal order go together
  a_order_eq: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      ((result.day_difference == '0) == (result.order == dvdd_pkg::ORDER_EQUAL)))
    else $error("order disagrees with day difference");

  // register write lands
  a_cfg_floor: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready && cfg.index == dvdd_pkg::REG_YEAR_FLOOR) |=>
      (year_floor == $past(cfg.data)))
    else $error("year floor write lost");
`endif

endmodule
